### rtl/sact_pkg.sv
// Package for the set-associative cache tag controller.
// Holds geometry constants, register codes, payload structs and state enum.
// No dependencies.
package sact_pkg;

  localparam int MaxSets       = 64;
  localparam int MaxWays       = 8;
  localparam int MaxBlockBytes = 64;
  localparam int AddrBits      = 48;
  localparam int SetIdxW       = $clog2(MaxSets);
  localparam int WayIdxW       = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int WayCntW       = $clog2(MaxWays + 1);
  localparam int TagW          = 48;
  localparam int StampW        = 32;
  localparam int PaddrW        = 5;

  // Register byte addresses
  localparam logic [PaddrW-1:0] RegSetBits      = 5'd0;
  localparam logic [PaddrW-1:0] RegWaysInUse    = 5'd4;
  localparam logic [PaddrW-1:0] RegBlockBits    = 5'd8;
  localparam logic [PaddrW-1:0] RegWriteThrough = 5'd12;
  localparam logic [PaddrW-1:0] RegWriteAlloc   = 5'd16;

  // Result kinds
  localparam logic [1:0] KindDone  = 2'd0;
  localparam logic [1:0] KindWback = 2'd1;
  localparam logic [1:0] KindFill  = 2'd2;
  localparam logic [1:0] KindFwd   = 2'd3;

  typedef struct packed {
    logic        func;
    logic [47:0] addr;
    logic [6:0]  nbytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] req_addr;
    logic [6:0]  req_bytes;
    logic        hit;
    logic        last_item;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TagW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDecide,
    StWback,
    StFill,
    StFwd,
    StDone
  } state_e;

endpackage

### rtl/set_assoc_cache_tag_controller.sv
// Set-associative cache tag controller, top level.
// Uses sact_pkg. Line state lives in one synchronous memory, one row per set.
//
// Usage: accesses enter on the in channel (in_valid_i/in_stall_o, in_item_i)
// and each produces one to three results on the out channel
// (out_valid_o/out_stall_i, out_item_o): optional writeback, fill or
// forwarded write, and then a final done result with last_item set.
// Each access is accepted, then its set row is read from the tag memory,
// then the ways are searched and a victim picked, then each result state
// holds while the receiver takes it. An allocating miss always passes the
// writeback slot, with or without a writeback. The set row read/modify/write
// goes through the single tag memory; one access is in flight.
// Reset clears the controller and runs a clearing pass over all MaxSets rows
// of the tag memory, during which no access is taken (register writes are
// taken). A stalled result holds in the output register; the block waits.
// Registers sit on an APB-style port at byte address 4*i.
module set_assoc_cache_tag_controller
  import sact_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [2:0] set_bits_q, block_bits_q;
  logic [3:0] ways_q;
  logic       wt_q, wa_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd6;
      ways_q       <= 4'd8;
      block_bits_q <= 3'd6;
      wt_q         <= 1'b0;
      wa_q         <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr)
        RegSetBits:      set_bits_q   <= pwdata[2:0];
        RegWaysInUse:    ways_q       <= pwdata[3:0];
        RegBlockBits:    block_bits_q <= pwdata[2:0];
        RegWriteThrough: wt_q         <= pwdata[0];
        RegWriteAlloc:   wa_q         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegSetBits:      prdata = {29'd0, set_bits_q};
      RegWaysInUse:    prdata = {28'd0, ways_q};
      RegBlockBits:    prdata = {29'd0, block_bits_q};
      RegWriteThrough: prdata = {31'd0, wt_q};
      RegWriteAlloc:   prdata = {31'd0, wa_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective geometry: clamp set and block sizes, clamp ways to 1..MaxWays
  logic [2:0] s_eff, b_eff;
  logic [WayCntW-1:0] ways_eff;
  always_comb begin
    s_eff = (32'(1) << set_bits_q) > MaxSets ? 3'(SetIdxW) : set_bits_q;
    b_eff = (32'(1) << block_bits_q) > MaxBlockBytes ?
            3'($clog2(MaxBlockBytes)) : block_bits_q;
    if (ways_q == 4'd0)                ways_eff = WayCntW'(1);
    else if (32'(ways_q) > MaxWays)    ways_eff = WayCntW'(MaxWays);
    else                               ways_eff = WayCntW'(ways_q);
  end

  // Tag memory, one row per set
  line_t [MaxWays-1:0] mem [MaxSets];
  line_t [MaxWays-1:0] row_q;
  line_t [MaxWays-1:0] wr_row;
  logic [SetIdxW-1:0]  rd_idx, wr_idx;
  logic                mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_idx] <= wr_row;
    row_q <= mem[rd_idx];
  end

  // Control state
  state_e state_q, state_d;
  logic [SetIdxW:0] clr_q;
  in_item_t   item_q;
  logic [31:0] cnt_q;
  logic [SetIdxW-1:0] set_q;
  logic [TagW-1:0]    tag_q;
  logic       hit_q, wb_q;
  logic [WayIdxW-1:0] way_q;
  logic [47:0] wb_addr_q;
  out_item_t  out_q;
  logic       out_v_q;

  logic clearing, in_acc, out_free;
  assign clearing   = !clr_q[SetIdxW];
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = clearing || (state_q != StIdle);
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // Address split of the incoming item
  logic [47:0] a_sh, off_mask;
  logic [3:0]  sb_sh;
  logic [SetIdxW-1:0] set_c;
  logic [TagW-1:0]    tag_c;
  always_comb begin
    sb_sh    = {1'b0, s_eff} + {1'b0, b_eff};
    a_sh     = in_item_i.addr >> b_eff;
    set_c    = SetIdxW'(a_sh & ((48'd1 << s_eff) - 48'd1));
    tag_c    = in_item_i.addr >> sb_sh;
    off_mask = (48'd1 << b_eff) - 48'd1;
  end

  // Way search and victim choice over the read row
  logic hit_c, inv_c;
  logic [WayIdxW-1:0] hway_c, iway_c, lway_c, vway_c;
  logic [StampW-1:0] best;
  line_t vline;
  always_comb begin
    hit_c = 1'b0; inv_c = 1'b0;
    hway_c = '0; iway_c = '0; lway_c = '0;
    best = row_q[0].stamp;
    for (int w = 0; w < MaxWays; w++) begin
      if (WayCntW'(w) < ways_eff) begin
        if (!hit_c && row_q[w].valid && row_q[w].tag == tag_q) begin
          hit_c = 1'b1; hway_c = WayIdxW'(w);
        end
        if (!inv_c && !row_q[w].valid) begin
          inv_c = 1'b1; iway_c = WayIdxW'(w);
        end
        if (row_q[w].stamp < best) begin
          best = row_q[w].stamp; lway_c = WayIdxW'(w);
        end
      end
    end
    vway_c = hit_c ? hway_c : (inv_c ? iway_c : lway_c);
    vline  = row_q[vway_c];
  end

  // Next state
  logic alloc_c;
  assign alloc_c = item_q.func || wa_q;
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_acc) state_d = StRead;
      StRead:   state_d = StDecide;
      StDecide: begin
        if (hit_c)        state_d = (!item_q.func && wt_q) ? StFwd : StDone;
        else if (!alloc_c) state_d = StFwd;
        else              state_d = StWback;
      end
      StWback:  if (out_free) state_d = StFill;
      StFill:   if (out_free) state_d = StDone;
      StFwd:    if (out_free) state_d = StDone;
      StDone:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Memory port and updated row; hold the read on the held set once accepted
  always_comb begin
    rd_idx = (state_q == StIdle) ? set_c : set_q;
    wr_idx = clearing ? clr_q[SetIdxW-1:0] : set_q;
    wr_row = row_q;
    mem_we = clearing;
    if (clearing) begin
      wr_row = '0;
    end else if (state_q == StDecide) begin
      mem_we = hit_c || alloc_c;
      wr_row[vway_c].stamp = cnt_q;
      if (hit_c) begin
        if (!item_q.func && !wt_q) wr_row[vway_c].dirty = 1'b1;
      end else begin
        wr_row[vway_c].valid = 1'b1;
        wr_row[vway_c].dirty = !item_q.func;
        wr_row[vway_c].tag   = tag_q;
      end
    end
  end

  // Result to present in each emitting state
  logic emit;
  out_item_t res;
  always_comb begin
    emit = 1'b0;
    res.kind = KindDone; res.req_addr = item_q.addr;
    res.req_bytes = item_q.nbytes; res.hit = hit_q; res.last_item = 1'b0;
    case (state_q)
      StWback: begin
        emit = wb_q; res.kind = KindWback; res.req_addr = wb_addr_q;
        res.req_bytes = 7'(8'd1 << b_eff);
      end
      StFill: begin
        emit = 1'b1; res.kind = KindFill; res.req_addr = item_q.addr & ~off_mask;
        res.req_bytes = 7'(8'd1 << b_eff);
      end
      StFwd:  begin emit = 1'b1; res.kind = KindFwd; end
      StDone: begin emit = 1'b1; res.last_item = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      clr_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      // Advance the saturating stamp counter per accepted access
      if (in_acc && cnt_q != 32'hFFFF_FFFF) cnt_q <= cnt_q + 32'd1;
      if (out_free) out_v_q <= emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      set_q  <= set_c;
      tag_q  <= tag_c;
    end
    if (state_q == StDecide) begin
      hit_q <= hit_c;
      way_q <= vway_c;
      wb_q  <= !hit_c && vline.stamp != '0 && vline.dirty;
      wb_addr_q <= (vline.tag << sb_sh) | (48'(set_q) << b_eff);
    end
    if (out_free && emit) out_q <= res;
  end

`ifndef SYNTHESIS
  // No transfer may start during the clearing pass
  a_no_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_acc) else $error("access accepted during clear");
  // A new access is only taken with the pipeline empty
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StRead) else $error("access overlap");
  // Done result marks the end
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.last_item == (out_q.kind == KindDone)))
    else $error("last flag mismatch");
  // Victim way stays in range
  a_way_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWback |-> WayCntW'(way_q) < ways_eff || $past(cfg_wr))
    else $error("victim way out of range");
`endif

endmodule
